@@ hw/rtl/ssr_pkg.sv @@
package ssr_pkg;

    // Field widths fixed by the interface.
    localparam int SIZE_W  = 4;
    localparam int NUM_W   = 27;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;

    // Derived widths for size arithmetic: cell width (size + 3) and bottom line (2 * size + 2).
    localparam int WID_W = SIZE_W + 1;
    localparam int BOT_W = SIZE_W + 2;

    // Binary to BCD conversion: a 27-bit value has at most nine decimal digits.
    localparam int BCD_DIGITS    = 9;
    localparam int BCD_W         = BCD_DIGITS * DIGIT_W;
    localparam int CNT_W         = 4;
    localparam int BITS_PER_STEP = 3;
    localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
    localparam int STEP_W        = 4;

    // Item kinds carried in tuser.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // ASCII codes of the picture.
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'd45;
    localparam logic [CHAR_W-1:0] CH_BAR   = 7'd124;
    localparam logic [CHAR_W-1:0] CH_NL    = 7'd10;

    // Segment bit positions.
    localparam int SEG_TOP    = 0;
    localparam int SEG_UP_R   = 1;
    localparam int SEG_LO_R   = 2;
    localparam int SEG_BOTTOM = 3;
    localparam int SEG_LO_L   = 4;
    localparam int SEG_UP_L   = 5;
    localparam int SEG_MIDDLE = 6;

    typedef logic [6:0] seg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    function automatic seg_t seg_decode(input logic [DIGIT_W-1:0] digit);
        seg_t segs;
        case (digit)
            4'd0: segs = 7'h3F;
            4'd1: segs = 7'h06;
            4'd2: segs = 7'h5B;
            4'd3: segs = 7'h4F;
            4'd4: segs = 7'h66;
            4'd5: segs = 7'h6D;
            4'd6: segs = 7'h7D;
            4'd7: segs = 7'h07;
            4'd8: segs = 7'h7F;
            4'd9: segs = 7'h6F;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

    // Double-dabble correction: add three to every BCD digit that is five or more.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                res[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/ssr_bcd_conv.sv @@
module ssr_bcd_conv
    import ssr_pkg::*;
#(
    parameter int MAX_DIGITS = 8,
    parameter int POS_W      = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [NUM_W-1:0]                     number,
    output conv_status_t                         status,
    output logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   digits,
    output logic [POS_W-1:0]                     digit_count
);

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    localparam logic [63:0] LIMIT = pow10(MAX_DIGITS);

    logic [NUM_W-1:0]  bin_reg,  bin_next;
    logic [BCD_W-1:0]  bcd_reg,  bcd_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [NUM_W-1:0]  clipped;
    logic [CNT_W-1:0]  cnt;

    // Numbers with more digits than the store holds saturate to all nines.
    assign clipped = (64'(number) >= LIMIT) ? NUM_W'(LIMIT - 64'd1) : number;

    always_comb begin
        logic [BCD_W+NUM_W-1:0] work;
        work = {bcd_reg, bin_reg};
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            work[BCD_W+NUM_W-1 -: BCD_W] = bcd_adjust(work[BCD_W+NUM_W-1 -: BCD_W]);
            work = work << 1;
        end
        bcd_next = work[BCD_W+NUM_W-1 -: BCD_W];
        bin_next = work[NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(CONV_STEPS);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= clipped;
            bcd_reg <= '0;
        end else if (busy_reg && step_reg != '0) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (step_reg == '0);

    // Count of significant digits; zero still shows one digit.
    always_comb begin
        cnt = CNT_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0) begin
                cnt = CNT_W'(i + 1);
            end
        end
    end

    assign digit_count = POS_W'(cnt);

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digits
        if (g < BCD_DIGITS) begin : g_real
            assign digits[g] = bcd_reg[g*DIGIT_W +: DIGIT_W];
        end else begin : g_zero
            assign digits[g] = '0;
        end
    end

endmodule

@@ hw/rtl/ssr_glyph.sv @@
module ssr_glyph
    import ssr_pkg::*;
#(
    parameter int LINE_W = 5,
    parameter int COL_W  = 4
) (
    input  logic [SIZE_W-1:0]  size,
    input  logic [LINE_W-1:0]  line_idx,
    input  logic [COL_W-1:0]   col_idx,
    input  logic [DIGIT_W-1:0] digit,
    output logic [CHAR_W-1:0]  character
);

    seg_t             segs;
    logic [BOT_W-1:0] ln;
    logic [BOT_W-1:0] s_b;
    logic [BOT_W-1:0] bottom;
    logic [WID_W-1:0] cl;
    logic [WID_W-1:0] s_w;
    logic             dash_col;
    logic             left_col;
    logic             right_col;

    assign segs      = seg_decode(digit);
    assign ln        = BOT_W'(line_idx);
    assign s_b       = BOT_W'(size);
    assign bottom    = {s_b[BOT_W-2:0], 1'b0} + BOT_W'(2);
    assign cl        = WID_W'(col_idx);
    assign s_w       = WID_W'(size);
    assign dash_col  = (cl >= WID_W'(1)) && (cl <= s_w);
    assign left_col  = (cl == '0);
    assign right_col = (cl == s_w + WID_W'(1));

    always_comb begin
        character = CH_SPACE;
        if (ln == '0) begin
            if (dash_col && segs[SEG_TOP]) character = CH_DASH;
        end else if (ln <= s_b) begin
            if (left_col && segs[SEG_UP_L]) character = CH_BAR;
            if (right_col && segs[SEG_UP_R]) character = CH_BAR;
        end else if (ln == s_b + BOT_W'(1)) begin
            if (dash_col && segs[SEG_MIDDLE]) character = CH_DASH;
        end else if (ln < bottom) begin
            if (left_col && segs[SEG_LO_L]) character = CH_BAR;
            if (right_col && segs[SEG_LO_R]) character = CH_BAR;
        end else begin
            // Bottom line, and any line left past it by a smaller size.
            if (dash_col && segs[SEG_BOTTOM]) character = CH_DASH;
        end
    end

endmodule

@@ hw/rtl/scaled_seven_segment_text_renderer.sv @@
// Scaled seven-segment text renderer.
// The slave channel takes beats whose tuser selects the kind: a load beat (tuser 0)
// carries a number in tdata and starts a new frame; a fetch beat (tuser 1) asks
// for the next character of the picture. Each fetch inside a frame yields one
// master beat carrying an ASCII code (space, dash, bar or newline); the newline
// that ends the bottom line has tlast set and closes the frame. Fetches outside
// a frame, and load beats, produce no master beat.
// The glyph size is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it. A fetch result
// appears on the master side in the cycle after acceptance, and fetches are taken
// one per cycle unless the receiver stalls or a load is converting. A load is split
// into decimal digits by an iterative double-dabble converter that handles three bits
// per cycle; s_tready stays low after a load beat while that converter runs. When the
// receiver stalls, the result register holds its beat and s_tready drops until the
// beat is taken, so no character is lost or repeated. Reset (aresetn low at a clock
// edge) clears the frame, the counters and m_tvalid, and sets the glyph size to 1.
// The digit store is not reset; it is always rewritten by a load before a frame reads it.
module scaled_seven_segment_text_renderer
    import ssr_pkg::*;
#(
    parameter int MAX_DIGITS = 8,
    parameter int MAX_SIZE   = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration: glyph size.
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    // Input channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [26:0] number, [31:27] zero
    input  logic              s_tuser,   // [0] mode
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [6:0] character, [7] zero
    output logic              m_tlast
);

    localparam int POS_W  = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LINE_W = $clog2(2 * MAX_SIZE + 3);
    localparam int COL_W  = $clog2(MAX_SIZE + 3);

    // Configuration register.
    logic [SIZE_W-1:0] glyph_size_reg;

    // Frame position state.
    logic [DIGIT_W-1:0] digit_store_reg [MAX_DIGITS];
    logic [POS_W-1:0]   digit_count_reg;
    logic [POS_W-1:0]   digit_pos_reg,    digit_pos_next;
    logic [LINE_W-1:0]  line_idx_reg,     line_idx_next;
    logic [COL_W-1:0]   col_idx_reg,      col_idx_next;
    logic               frame_active_reg, frame_active_next;

    // Result register.
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    conv_status_t                       conv_stat;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] conv_digits;
    logic [POS_W-1:0]                   conv_count;

    logic               s_accept;
    logic               load_go;
    logic               fetch_go;
    logic [SIZE_W-1:0]  eff_size;
    logic [WID_W-1:0]   cell_width;
    logic [BOT_W-1:0]   bottom;
    logic [WID_W-1:0]   col_inc;
    logic               newline_due;
    logic [POS_W-1:0]   read_idx;
    logic [DIGIT_W-1:0] cur_digit;
    logic [CHAR_W-1:0]  glyph_char;

    // The converter owns the input while busy; otherwise a beat is taken whenever the
    // result register is free or being emptied in this cycle.
    assign s_tready = !conv_stat.busy && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign load_go  = s_accept && (s_tuser == MODE_LOAD);
    assign fetch_go = s_accept && (s_tuser == MODE_FETCH) && frame_active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_size_reg <= SIZE_W'(1);
        end else if (cfg_wr_en) begin
            glyph_size_reg <= cfg_wr_data;
        end
    end

    // Size zero draws as one, sizes above the maximum saturate.
    always_comb begin
        if (glyph_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (glyph_size_reg > SIZE_W'(MAX_SIZE)) begin
            eff_size = SIZE_W'(MAX_SIZE);
        end else begin
            eff_size = glyph_size_reg;
        end
    end

    assign cell_width = WID_W'(eff_size) + WID_W'(3);
    assign bottom     = {1'b0, eff_size, 1'b0} + BOT_W'(2);

    ssr_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS),
        .POS_W      (POS_W)
    ) u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (load_go),
        .number      (s_tdata[NUM_W-1:0]),
        .status      (conv_stat),
        .digits      (conv_digits),
        .digit_count (conv_count)
    );

    // The store holds digits least significant first, so the most significant digit
    // of the picture sits at index count - 1.
    assign newline_due = (digit_pos_reg >= digit_count_reg);
    assign read_idx    = digit_count_reg - digit_pos_reg - POS_W'(1);
    assign cur_digit   = digit_store_reg[read_idx[DIDX_W-1:0]];

    ssr_glyph #(
        .LINE_W (LINE_W),
        .COL_W  (COL_W)
    ) u_glyph (
        .size      (eff_size),
        .line_idx  (line_idx_reg),
        .col_idx   (col_idx_reg),
        .digit     (cur_digit),
        .character (glyph_char)
    );

    assign col_inc = WID_W'(col_idx_reg) + WID_W'(1);

    always_comb begin
        digit_pos_next    = digit_pos_reg;
        line_idx_next     = line_idx_reg;
        col_idx_next      = col_idx_reg;
        frame_active_next = frame_active_reg;
        char_next         = glyph_char;
        last_next         = 1'b0;
        if (newline_due) begin
            char_next      = CH_NL;
            digit_pos_next = '0;
            col_idx_next   = '0;
            // A line past the bottom, left by a smaller size, also closes the frame.
            if (BOT_W'(line_idx_reg) >= bottom) begin
                last_next         = 1'b1;
                frame_active_next = 1'b0;
                line_idx_next     = '0;
            end else begin
                line_idx_next = line_idx_reg + LINE_W'(1);
            end
        end else if (col_inc >= cell_width) begin
            col_idx_next   = '0;
            digit_pos_next = digit_pos_reg + POS_W'(1);
        end else begin
            col_idx_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= '0;
            digit_pos_reg    <= '0;
            line_idx_reg     <= '0;
            col_idx_reg      <= '0;
            frame_active_reg <= 1'b0;
        end else if (conv_stat.done) begin
            digit_count_reg  <= conv_count;
            digit_pos_reg    <= '0;
            line_idx_reg     <= '0;
            col_idx_reg      <= '0;
            frame_active_reg <= 1'b1;
        end else if (load_go) begin
            // The old frame is dropped; the new one opens when the digits are ready.
            frame_active_reg <= 1'b0;
        end else if (fetch_go) begin
            digit_pos_reg    <= digit_pos_next;
            line_idx_reg     <= line_idx_next;
            col_idx_reg      <= col_idx_next;
            frame_active_reg <= frame_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_stat.done) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digit_store_reg[i] <= conv_digits[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fetch_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_go) begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hw/rtl/ssr_checker.sv @@
module ssr_checker
    import ssr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A load beat hands the input to the digit converter in the next cycle.
    a_load_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_LOAD) |=> !s_tready)
        else $error("input ready right after a load beat");

    // Only picture characters come out.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == {1'b0, CH_SPACE}) || (m_tdata == {1'b0, CH_DASH}) ||
                     (m_tdata == {1'b0, CH_BAR}) || (m_tdata == {1'b0, CH_NL}))
        else $error("character outside the picture set");

    // The frame ends on a newline.
    a_last_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata == {1'b0, CH_NL}))
        else $error("end of frame not on a newline");

    // A new result beat follows an accepted fetch beat.
    a_from_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == MODE_FETCH)))
        else $error("result beat without a fetch");

endmodule

bind scaled_seven_segment_text_renderer ssr_checker u_ssr_checker (.*);
